// ----- rtl/assert_macros.svh -----
// assertion helpers of the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is asserted
`define BMC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("bmc checker: same-cycle property failed");

// next-cycle implication, held off while reset is asserted
`define BMC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("bmc checker: next-cycle property failed");

`endif

// ----- rtl/bmc_pkg.sv -----
// ----------------------------------------------------------------------------
// bmc_pkg
// Types and constants of the backtracking maze carver.
// ----------------------------------------------------------------------------
package bmc_pkg;

  localparam int RND_W   = 16;
  localparam int COORD_W = 4;
  localparam int VT_W    = 9;

  localparam logic FUNC_STEP    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [1:0] {
    KIND_CARVED  = 2'd0,
    KIND_BACK    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_RESTART = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_WEST  = 2'd0,
    DIR_NORTH = 2'd1,
    DIR_EAST  = 2'd2,
    DIR_SOUTH = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PICK,
    S_CARVE,
    S_POP,
    S_POPW,
    S_FIN
  } state_t;

  typedef struct packed {
    logic found;
    dir_t dir;
  } pick_t;

endpackage

// ----- rtl/bmc_if.sv -----
// ----------------------------------------------------------------------------
// bmc_if
// Valid/ready channels of the maze carver: step requests and step results.
// ----------------------------------------------------------------------------
interface bmc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [bmc_pkg::RND_W-1:0]   random_word;

  modport source (output valid, output func, output random_word, input ready);
  modport sink   (input valid, input func, input random_word, output ready);
endinterface

interface bmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [bmc_pkg::COORD_W-1:0] from_x;
  logic [bmc_pkg::COORD_W-1:0] from_y;
  logic [bmc_pkg::COORD_W-1:0] to_x;
  logic [bmc_pkg::COORD_W-1:0] to_y;
  logic [1:0]                  wall_dir;
  logic [bmc_pkg::VT_W-1:0]    visited_total;

  modport source (output valid, output kind, output from_x, output from_y, output to_x,
                  output to_y, output wall_dir, output visited_total, input ready);
  modport sink   (input valid, input kind, input from_x, input from_y, input to_x,
                  input to_y, input wall_dir, input visited_total, output ready);
endinterface

// ----- rtl/backtracking_maze_carver.sv -----
// ----------------------------------------------------------------------------
// backtracking_maze_carver
// Depth-first maze carve, one step per transaction, with the visited map and
// the path stack held in synchronous RAMs.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  in_chan  | in  | func, random_word                            | valid/ready
//  out_chan | out | kind, from/to x,y, wall_dir, visited_total   | valid/ready
//
//  a step makes four neighbour reads through the single read port of the
//  visited RAM, then a pick and a write back, or a stack pop on a backtrack
//  reset and restart run a clearing pass over the visited RAM, all
//  2**(clog2(GRID_WIDTH) + clog2(GRID_HEIGHT)) entries, with in_chan.ready low
//  a new transaction is taken while the previous result waits in the
//  output register; a result that finds that register full waits for it
// ----------------------------------------------------------------------------
module backtracking_maze_carver #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bmc_in_if.sink     in_chan,
  bmc_out_if.source  out_chan
);

  localparam int XW     = $clog2(GRID_WIDTH);
  localparam int YW     = $clog2(GRID_HEIGHT);
  localparam int AW     = XW + YW;
  localparam int MDEPTH = 1 << AW;
  localparam int NCELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int SAW    = $clog2(NCELLS);
  localparam int CNTW   = $clog2(NCELLS + 1);

  bmc_pkg::state_t state_r, state_nxt;

  logic [XW-1:0]   cur_x_r, cur_x_nxt;
  logic [YW-1:0]   cur_y_r, cur_y_nxt;
  logic [XW-1:0]   from_x_r, from_x_nxt;
  logic [YW-1:0]   from_y_r, from_y_nxt;
  logic [XW-1:0]   to_x_r, to_x_nxt;
  logic [YW-1:0]   to_y_r, to_y_nxt;
  logic [CNTW-1:0] depth_r, depth_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [bmc_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            restart_r, restart_nxt;
  logic [3:0]      cand_r, cand_nxt;
  logic [1:0]      rd_dir_r, rd_dir_nxt;
  logic            rd_vld_r, rd_vld_nxt;
  logic [1:0]      rd_tag_r, rd_tag_nxt;
  logic            rd_inb_r, rd_inb_nxt;
  bmc_pkg::kind_t  res_kind_r, res_kind_nxt;
  bmc_pkg::dir_t   res_dir_r, res_dir_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic [bmc_pkg::COORD_W-1:0] out_from_x_r, out_from_x_nxt;
  logic [bmc_pkg::COORD_W-1:0] out_from_y_r, out_from_y_nxt;
  logic [bmc_pkg::COORD_W-1:0] out_to_x_r, out_to_x_nxt;
  logic [bmc_pkg::COORD_W-1:0] out_to_y_r, out_to_y_nxt;
  logic [1:0]      out_dir_r, out_dir_nxt;
  logic [bmc_pkg::VT_W-1:0] out_total_r, out_total_nxt;

  logic            in_acc;
  logic            out_free;
  logic            done;
  logic [CNTW-1:0] depth_m1;
  logic [XW-1:0]   x_dec, x_inc;
  logic [YW-1:0]   y_dec, y_inc;

  logic            vis_we;
  logic [AW-1:0]   vis_waddr;
  logic            vis_wdata;
  logic [AW-1:0]   vis_raddr;
  logic            vis_rdata;

  logic            stk_we;
  logic [SAW-1:0]  stk_waddr;
  logic [AW-1:0]   stk_wdata;
  logic [SAW-1:0]  stk_raddr;
  logic [AW-1:0]   stk_rdata;

  bmc_pkg::pick_t  pick;

  bmc_ram #(.WIDTH(1), .DEPTH(MDEPTH)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  bmc_ram #(.WIDTH(AW), .DEPTH(NCELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  bmc_pick u_pick (
    .cand (cand_r),
    .rnd  (rnd_r),
    .pick (pick)
  );

  assign in_chan.ready = (state_r == bmc_pkg::S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign done          = (count_r >= CNTW'(NCELLS));
  assign depth_m1      = depth_r - 1'b1;
  assign x_dec         = cur_x_r - 1'b1;
  assign x_inc         = cur_x_r + 1'b1;
  assign y_dec         = cur_y_r - 1'b1;
  assign y_inc         = cur_y_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmc_pkg::S_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = restart_r ? bmc_pkg::S_FIN : bmc_pkg::S_IDLE;
        end
      end
      bmc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_chan.func == bmc_pkg::FUNC_RESTART) begin
            state_nxt = bmc_pkg::S_CLEAR;
          end else if (done) begin
            state_nxt = bmc_pkg::S_FIN;
          end else begin
            state_nxt = bmc_pkg::S_READ;
          end
        end
      end
      bmc_pkg::S_READ: begin
        if (rd_dir_r == bmc_pkg::DIR_SOUTH) begin
          state_nxt = bmc_pkg::S_DRAIN;
        end
      end
      bmc_pkg::S_DRAIN: state_nxt = bmc_pkg::S_PICK;
      bmc_pkg::S_PICK:  state_nxt = pick.found ? bmc_pkg::S_CARVE : bmc_pkg::S_POP;
      bmc_pkg::S_CARVE: state_nxt = bmc_pkg::S_FIN;
      bmc_pkg::S_POP:   state_nxt = (depth_r != '0) ? bmc_pkg::S_POPW : bmc_pkg::S_FIN;
      bmc_pkg::S_POPW:  state_nxt = bmc_pkg::S_FIN;
      bmc_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = bmc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bmc_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    from_x_nxt     = from_x_r;
    from_y_nxt     = from_y_r;
    to_x_nxt       = to_x_r;
    to_y_nxt       = to_y_r;
    depth_nxt      = depth_r;
    count_nxt      = count_r;
    rnd_nxt        = rnd_r;
    clr_addr_nxt   = clr_addr_r;
    restart_nxt    = restart_r;
    cand_nxt       = cand_r;
    rd_dir_nxt     = rd_dir_r;
    rd_vld_nxt     = 1'b0;
    rd_tag_nxt     = rd_tag_r;
    rd_inb_nxt     = rd_inb_r;
    res_kind_nxt   = res_kind_r;
    res_dir_nxt    = res_dir_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_kind_nxt   = out_kind_r;
    out_from_x_nxt = out_from_x_r;
    out_from_y_nxt = out_from_y_r;
    out_to_x_nxt   = out_to_x_r;
    out_to_y_nxt   = out_to_y_r;
    out_dir_nxt    = out_dir_r;
    out_total_nxt  = out_total_r;

    vis_we    = 1'b0;
    vis_waddr = {to_y_r, to_x_r};
    vis_wdata = 1'b1;
    vis_raddr = {cur_y_r, x_dec};
    stk_we    = 1'b0;
    stk_waddr = depth_r[SAW-1:0];
    stk_wdata = {cur_y_r, cur_x_r};
    stk_raddr = depth_m1[SAW-1:0];

    // neighbour bit returns in the cycle after its read
    if (rd_vld_r) begin
      cand_nxt[rd_tag_r] = rd_inb_r && !vis_rdata;
    end

    case (state_r)
      bmc_pkg::S_CLEAR: begin
        vis_we       = 1'b1;
        vis_waddr    = clr_addr_r;
        vis_wdata    = (clr_addr_r == '0);
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      bmc_pkg::S_IDLE: begin
        if (in_acc) begin
          from_x_nxt  = cur_x_r;
          from_y_nxt  = cur_y_r;
          to_x_nxt    = cur_x_r;
          to_y_nxt    = cur_y_r;
          rnd_nxt     = in_chan.random_word;
          rd_dir_nxt  = bmc_pkg::DIR_WEST;
          cand_nxt    = 4'd0;
          res_dir_nxt = bmc_pkg::DIR_WEST;
          if (in_chan.func == bmc_pkg::FUNC_RESTART) begin
            restart_nxt  = 1'b1;
            clr_addr_nxt = '0;
            cur_x_nxt    = '0;
            cur_y_nxt    = '0;
            to_x_nxt     = '0;
            to_y_nxt     = '0;
            depth_nxt    = '0;
            count_nxt    = CNTW'(1);
            res_kind_nxt = bmc_pkg::KIND_RESTART;
          end else if (done) begin
            res_kind_nxt = bmc_pkg::KIND_DONE;
          end
        end
      end
      bmc_pkg::S_READ: begin
        rd_vld_nxt = 1'b1;
        rd_tag_nxt = rd_dir_r;
        rd_dir_nxt = rd_dir_r + 2'd1;
        case (rd_dir_r)
          bmc_pkg::DIR_WEST: begin
            vis_raddr  = {cur_y_r, x_dec};
            rd_inb_nxt = (cur_x_r != '0);
          end
          bmc_pkg::DIR_NORTH: begin
            vis_raddr  = {y_dec, cur_x_r};
            rd_inb_nxt = (cur_y_r != '0);
          end
          bmc_pkg::DIR_EAST: begin
            vis_raddr  = {cur_y_r, x_inc};
            rd_inb_nxt = (cur_x_r != XW'(GRID_WIDTH - 1));
          end
          default: begin
            vis_raddr  = {y_inc, cur_x_r};
            rd_inb_nxt = (cur_y_r != YW'(GRID_HEIGHT - 1));
          end
        endcase
      end
      bmc_pkg::S_PICK: begin
        res_dir_nxt = pick.dir;
        if (pick.found) begin
          res_kind_nxt = bmc_pkg::KIND_CARVED;
          case (pick.dir)
            bmc_pkg::DIR_WEST:  to_x_nxt = x_dec;
            bmc_pkg::DIR_NORTH: to_y_nxt = y_dec;
            bmc_pkg::DIR_EAST:  to_x_nxt = x_inc;
            default:            to_y_nxt = y_inc;
          endcase
        end else begin
          res_kind_nxt = bmc_pkg::KIND_BACK;
          res_dir_nxt  = bmc_pkg::DIR_WEST;
        end
      end
      bmc_pkg::S_CARVE: begin
        vis_we    = 1'b1;
        stk_we    = (depth_r < CNTW'(NCELLS));
        depth_nxt = stk_we ? depth_r + 1'b1 : depth_r;
        count_nxt = count_r + 1'b1;
        cur_x_nxt = to_x_r;
        cur_y_nxt = to_y_r;
      end
      bmc_pkg::S_POP: begin
        if (depth_r != '0) begin
          depth_nxt = depth_m1;
        end
      end
      bmc_pkg::S_POPW: begin
        cur_x_nxt = stk_rdata[XW-1:0];
        cur_y_nxt = stk_rdata[AW-1:XW];
        to_x_nxt  = stk_rdata[XW-1:0];
        to_y_nxt  = stk_rdata[AW-1:XW];
      end
      bmc_pkg::S_FIN: begin
        if (out_free) begin
          restart_nxt    = 1'b0;
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_from_x_nxt = bmc_pkg::COORD_W'(from_x_r);
          out_from_y_nxt = bmc_pkg::COORD_W'(from_y_r);
          out_to_x_nxt   = bmc_pkg::COORD_W'(to_x_r);
          out_to_y_nxt   = bmc_pkg::COORD_W'(to_y_r);
          out_dir_nxt    = res_dir_r;
          out_total_nxt  = bmc_pkg::VT_W'(count_r);
        end
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmc_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      restart_r   <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      depth_r     <= '0;
      count_r     <= CNTW'(1);
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      restart_r   <= restart_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      depth_r     <= depth_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_x_r     <= from_x_nxt;
    from_y_r     <= from_y_nxt;
    to_x_r       <= to_x_nxt;
    to_y_r       <= to_y_nxt;
    rnd_r        <= rnd_nxt;
    cand_r       <= cand_nxt;
    rd_dir_r     <= rd_dir_nxt;
    rd_tag_r     <= rd_tag_nxt;
    rd_inb_r     <= rd_inb_nxt;
    res_kind_r   <= res_kind_nxt;
    res_dir_r    <= res_dir_nxt;
    out_kind_r   <= out_kind_nxt;
    out_from_x_r <= out_from_x_nxt;
    out_from_y_r <= out_from_y_nxt;
    out_to_x_r   <= out_to_x_nxt;
    out_to_y_r   <= out_to_y_nxt;
    out_dir_r    <= out_dir_nxt;
    out_total_r  <= out_total_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.kind          = out_kind_r;
  assign out_chan.from_x        = out_from_x_r;
  assign out_chan.from_y        = out_from_y_r;
  assign out_chan.to_x          = out_to_x_r;
  assign out_chan.to_y          = out_to_y_r;
  assign out_chan.wall_dir      = out_dir_r;
  assign out_chan.visited_total = out_total_r;

endmodule

// ----- rtl/bmc_ram.sv -----
// ----------------------------------------------------------------------------
// bmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bmc_pick.sv -----
// ----------------------------------------------------------------------------
// bmc_pick
// Chooses one open neighbour: random word modulo the open count, then the
// matching set bit in west, north, east, south order.
// ----------------------------------------------------------------------------
module bmc_pick (
  input  logic [3:0]                cand,
  input  logic [bmc_pkg::RND_W-1:0] rnd,
  output bmc_pkg::pick_t            pick
);

  // 4 = 1 mod 3, so base-4 digit sums keep the residue
  function automatic logic [1:0] mod3(input logic [bmc_pkg::RND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < bmc_pkg::RND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  logic [2:0] n;
  logic [1:0] idx;
  logic [1:0] seen;
  logic       hit;

  always_comb begin
    n = 3'(cand[0]) + 3'(cand[1]) + 3'(cand[2]) + 3'(cand[3]);
    case (n)
      3'd2:    idx = {1'b0, rnd[0]};
      3'd3:    idx = mod3(rnd);
      3'd4:    idx = rnd[1:0];
      default: idx = 2'd0;
    endcase

    seen      = 2'd0;
    hit       = 1'b0;
    pick.dir  = bmc_pkg::DIR_WEST;
    for (int d = 0; d < 4; d++) begin
      if (cand[d]) begin
        if (!hit && seen == idx) begin
          pick.dir = bmc_pkg::dir_t'(d[1:0]);
          hit      = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
    pick.found = (n != 3'd0);
  end

endmodule

// ----- rtl/bmc_checker.sv -----
// ----------------------------------------------------------------------------
// bmc_checker
// Port-level checks of the maze carver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [bmc_pkg::COORD_W-1:0] out_from_x,
  input logic [bmc_pkg::COORD_W-1:0] out_from_y,
  input logic [bmc_pkg::COORD_W-1:0] out_to_x,
  input logic [bmc_pkg::COORD_W-1:0] out_to_y,
  input logic [1:0]                  out_wall_dir,
  input logic [bmc_pkg::VT_W-1:0]    out_visited_total
);

  logic carve_west;
  logic carve_north;

  assign carve_west  = out_valid && out_kind == bmc_pkg::KIND_CARVED &&
                       out_wall_dir == bmc_pkg::DIR_WEST;
  assign carve_north = out_valid && out_kind == bmc_pkg::KIND_CARVED &&
                       out_wall_dir == bmc_pkg::DIR_NORTH;

  // a stalled result stays offered
  `BMC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one step in flight: ready drops right after a transaction
  `BMC_ASSERT_NEXT(a_in_single, clk, rst_n, in_valid && in_ready, !in_ready)

  `BMC_ASSERT_NOW(a_restart_home, clk, rst_n, out_valid && out_kind == bmc_pkg::KIND_RESTART, out_to_x == '0 && out_to_y == '0 && out_visited_total == 9'd1)

  `BMC_ASSERT_NOW(a_done_still, clk, rst_n, out_valid && out_kind == bmc_pkg::KIND_DONE, out_to_x == out_from_x && out_to_y == out_from_y && out_wall_dir == 2'd0)

  `BMC_ASSERT_NOW(a_carve_adjacent, clk, rst_n, carve_west || carve_north, (carve_west && out_to_x == out_from_x - 4'd1 && out_to_y == out_from_y) || (carve_north && out_to_y == out_from_y - 4'd1 && out_to_x == out_from_x))

endmodule

bind backtracking_maze_carver bmc_checker u_bmc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_kind          (out_chan.kind),
  .out_from_x        (out_chan.from_x),
  .out_from_y        (out_chan.from_y),
  .out_to_x          (out_chan.to_x),
  .out_to_y          (out_chan.to_y),
  .out_wall_dir      (out_chan.wall_dir),
  .out_visited_total (out_chan.visited_total)
);

// ----- sim/maze_carver_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_carver_checker
// Watches both channels of the maze carver and keeps its own copy of the
// carve: visited cells, the path back, the current cell and the cell count.
// Each accepted request yields one expected step result; each accepted result
// is checked field by field against the oldest one still waiting.
// ----------------------------------------------------------------------------
module maze_carver_checker #(
  parameter int GRID_WIDTH  = 16,
  parameter int GRID_HEIGHT = 16
) (
  input  logic clk,
  input  logic rst_n,
  bmc_in_if    in_mon,
  bmc_out_if   out_mon,
  output int   mismatches,
  output int   pending,
  output int   checked,
  output int   finished_seen
);
  import bmc_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

  typedef struct packed {
    kind_t                kind;
    logic [COORD_W-1:0]   from_x;
    logic [COORD_W-1:0]   from_y;
    logic [COORD_W-1:0]   to_x;
    logic [COORD_W-1:0]   to_y;
    dir_t                 wall;
    logic [VT_W-1:0]      total;
  } step_result_t;

  bit           visited [CELLS];
  int           trail [CELLS];
  int           trail_depth;
  int           here;
  int           cells_seen;
  step_result_t expected_q [$];

  function automatic void clear_grid();
    foreach (visited[i]) visited[i] = 1'b0;
    visited[0]  = 1'b1;
    trail_depth = 0;
    here        = 0;
    cells_seen  = 1;
  endfunction

  function automatic step_result_t advance_carve(logic f, logic [RND_W-1:0] w);
    step_result_t r;
    int           nb_cell [4];
    dir_t         nb_dir [4];
    int           n;
    int           x;
    int           y;
    int           pick;
    x        = here % GRID_WIDTH;
    y        = here / GRID_WIDTH;
    n        = 0;
    r.from_x = COORD_W'(x);
    r.from_y = COORD_W'(y);
    r.wall   = DIR_WEST;
    if (f == FUNC_RESTART) begin
      clear_grid();
      r.kind = KIND_RESTART;
    end else if (cells_seen >= CELLS) begin
      r.kind = KIND_DONE;
    end else begin
      // neighbours gathered west, north, east, south
      if (x > 0 && !visited[here - 1]) begin
        nb_cell[n] = here - 1;
        nb_dir[n]  = DIR_WEST;
        n++;
      end
      if (y > 0 && !visited[here - GRID_WIDTH]) begin
        nb_cell[n] = here - GRID_WIDTH;
        nb_dir[n]  = DIR_NORTH;
        n++;
      end
      if (x + 1 < GRID_WIDTH && !visited[here + 1]) begin
        nb_cell[n] = here + 1;
        nb_dir[n]  = DIR_EAST;
        n++;
      end
      if (y + 1 < GRID_HEIGHT && !visited[here + GRID_WIDTH]) begin
        nb_cell[n] = here + GRID_WIDTH;
        nb_dir[n]  = DIR_SOUTH;
        n++;
      end
      if (n != 0) begin
        pick               = int'(w) % n;
        trail[trail_depth] = here;
        trail_depth++;
        here               = nb_cell[pick];
        visited[here]      = 1'b1;
        cells_seen++;
        r.kind             = KIND_CARVED;
        r.wall             = nb_dir[pick];
      end else begin
        if (trail_depth != 0) begin
          trail_depth--;
          here = trail[trail_depth];
        end
        r.kind = KIND_BACK;
      end
    end
    r.to_x  = COORD_W'(here % GRID_WIDTH);
    r.to_y  = COORD_W'(here / GRID_WIDTH);
    r.total = VT_W'(cells_seen);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [VT_W-1:0] got, logic [VT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d", checked, name, got, want));
  endtask

  always @(posedge clk) begin
    step_result_t want;
    if (!rst_n) begin
      clear_grid();
      expected_q.delete();
      mismatches    = 0;
      checked       = 0;
      finished_seen = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting, kind %0d", out_mon.kind));
        end else begin
          want = expected_q.pop_front();
          compare_field("kind", out_mon.kind, want.kind);
          compare_field("from_x", out_mon.from_x, want.from_x);
          compare_field("from_y", out_mon.from_y, want.from_y);
          compare_field("to_x", out_mon.to_x, want.to_x);
          compare_field("to_y", out_mon.to_y, want.to_y);
          compare_field("wall_dir", out_mon.wall_dir, want.wall);
          compare_field("visited_total", out_mon.visited_total, want.total);
          if (want.kind == KIND_DONE) finished_seen++;
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.insert(expected_q.size(), advance_carve(in_mon.func, in_mon.random_word));
    end
    pending = expected_q.size();
  end

endmodule

// ----- sim/backtracking_maze_carver_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backtracking_maze_carver_tb
// Drives carving steps and restarts into the maze carver: a short hand-built
// walk with a dead end, then sessions of random steps, some long enough to
// finish the maze. Requests come in bursts, results are taken with stalls,
// and the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module backtracking_maze_carver_tb;
  import bmc_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 300;

  logic clk;
  logic rst_n;

  bmc_in_if  in_chan ();
  bmc_out_if out_chan ();

  int mismatch_count;
  int pending_results;
  int results_checked;
  int done_results;
  int burst_left;
  int idle_cycles;
  int requests_sent;
  int restarts_sent;
  int random_sent;
  bit hold_off_due;

  backtracking_maze_carver DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  maze_carver_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .mismatches    (mismatch_count),
    .pending       (pending_results),
    .checked       (results_checked),
    .finished_seen (done_results)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // no transaction on either channel for too long means the block is stuck
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results pending", idle_cycles,
               pending_results);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [RND_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return RND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic offer_request(logic f, logic [RND_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= f;
    in_chan.random_word <= w;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    burst_left--;
    requests_sent++;
    if (f == FUNC_RESTART) restarts_sent++;
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
    burst_left = 0;
  endtask

  task automatic random_request(logic f);
    if (random_sent == 120) hold_off_due = 1'b1;
    if (random_sent == 900) drain_results();
    offer_request(f, pick_word());
    random_sent++;
  endtask

  // receiver: free stretches, choppy stretches, and one long hold-off
  initial begin
    out_chan.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        @(negedge clk);
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        @(negedge clk);
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        repeat ($urandom_range(5, 30)) begin
          @(negedge clk);
          out_chan.ready <= ($urandom_range(0, 9) < 6);
        end
      end
    end
  end

  initial begin
    int  steps;
    int  sessions;
    bit  full_run;
    in_chan.valid       = 1'b0;
    in_chan.func        = FUNC_STEP;
    in_chan.random_word = '0;
    rst_n               = 1'b0;
    burst_left          = 0;
    requests_sent       = 0;
    restarts_sent       = 0;
    random_sent         = 0;
    sessions            = 0;
    hold_off_due        = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // restart at the origin, then a walk that boxes in cell (0,1)
    offer_request(FUNC_RESTART, '1);
    offer_request(FUNC_STEP, '0);          // east to (1,0)
    offer_request(FUNC_STEP, '1);          // south to (1,1)
    offer_request(FUNC_STEP, 16'hFFFE);    // south to (1,2)
    offer_request(FUNC_STEP, 16'h0003);    // west to (0,2)
    offer_request(FUNC_STEP, 16'h8000);    // north to (0,1), a dead end
    offer_request(FUNC_STEP, 16'h5555);    // back to (0,2)
    offer_request(FUNC_STEP, 16'hAAAA);    // only south is left
    offer_request(FUNC_RESTART, 16'h1234); // restart away from the origin
    repeat (6) offer_request(FUNC_STEP, pick_word());
    offer_request(FUNC_RESTART, '0);
    repeat (4) offer_request(FUNC_STEP, pick_word());
    drain_results();

    // sessions of random steps, each closed by a restart; full runs finish
    // the maze and keep stepping on the finished grid
    while (random_sent < RANDOM_ITEMS) begin
      full_run = (sessions == 0) || ($urandom_range(0, 1) == 1);
      steps    = full_run ? $urandom_range(520, 540) : $urandom_range(1, 150);
      // last session is cut short so the run ends near the item budget
      if (steps > RANDOM_ITEMS - 1 - random_sent) steps = RANDOM_ITEMS - 1 - random_sent;
      repeat (steps) random_request(FUNC_STEP);
      random_request(FUNC_RESTART);
      sessions++;
    end

    in_chan.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (20) @(posedge clk);

    $display("%0d requests sent (%0d restarts) in %0d random sessions", requests_sent,
             restarts_sent, sessions);
    $display("%0d results checked, %0d of them steps on a finished maze", results_checked,
             done_results);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
